FILE: hw/rtl/gph_pkg.sv
// ----------------------------------------------------------------------------
// gph_pkg
// Shared widths, constants, stage record and arctangent table for the
// gradient phase pipeline.
// ----------------------------------------------------------------------------
package gph_pkg;

   // Widths of the input gradients and the output phase.
   localparam int GradW  = 16;
   localparam int PhaseW = 8;

   // Fixed-point fraction bits of the gradient datapath.
   localparam int FracW = 24;

   // Datapath width: gradient plus fraction, plus headroom for the
   // rotation, the quadrant fold and the CORDIC gain.
   localparam int XW = GradW + FracW + 4;

   // Angle width: 2^31 is pi, with room for overshoot and sign.
   localparam int ZW = 34;

   // Stage count, limited to the length of the arctangent table.
   localparam int CordicStages = 16;
   localparam int TableLen     = 24;
   localparam int NumStages    = (CordicStages > TableLen) ? TableLen : CordicStages;

   // Width of a stage index.
   localparam int IdxW = 5;

   // Angle constants.
   localparam logic [ZW-1:0] PiUnits     = ZW'(64'h0000_0000_8000_0000);
   localparam logic [ZW-1:0] HalfPiUnits = ZW'(64'h0000_0000_4000_0000);

   // One pipeline stage: valid bit, vector and accumulated angle.
   typedef struct packed {
      logic          vld;
      logic [XW-1:0] x;
      logic [XW-1:0] y;
      logic [ZW-1:0] z;
   } gph_stage_type;

   // Arctangent of 2^-i in units of pi/2^31.
   function automatic logic [ZW-1:0] gph_atan(input logic [IdxW-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051E;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2FA;
         5'd15:   val = 32'h0000_517D;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A30;
         5'd19:   val = 32'h0000_0518;
         5'd20:   val = 32'h0000_028C;
         5'd21:   val = 32'h0000_0146;
         5'd22:   val = 32'h0000_00A3;
         5'd23:   val = 32'h0000_0051;
         default: val = 32'h0000_0000;
      endcase
      return ZW'(val);
   endfunction

endpackage

FILE: hw/rtl/gradient_phase_u8.sv
// ----------------------------------------------------------------------------
// gradient_phase_u8
// Per-pixel gradient phase: atan2(grad_y, grad_x) scaled to an 8-bit code
// by a pipelined fixed-point CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_grad_x[15:0], req_grad_y[15:0]
//   rsp_      out        rsp_valid / rsp_stall  rsp_phase[7:0]
//
// One request is taken per clock while req_stall is low; its response passes
// through one fold stage, one register per CORDIC iteration and the output
// register.
// Reset is synchronous and clears only the valid bits of every stage.
// A stalled response freezes only the stages behind it that hold data;
// empty stages keep filling, so requests are still taken until the pipe is full.
// ----------------------------------------------------------------------------
module gradient_phase_u8
   import gph_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [GradW-1:0] req_grad_x,
   input  logic signed [GradW-1:0] req_grad_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PhaseW-1:0]       rsp_phase
);

   // Stage 0 is the fold register, stage k+1 follows CORDIC iteration k.
   gph_stage_type           stg [0:NumStages];
   logic [NumStages+1:0]    adv;

   // A stage may load when it is empty or the one after it moves on.
   assign adv[NumStages+1] = !rsp_valid || !rsp_stall;

   genvar k;
   generate
      for (k = 0; k <= NumStages; k++) begin : g_adv
         assign adv[k] = !stg[k].vld || adv[k+1];
      end
   endgenerate

   assign req_stall = !adv[0];

   // Quadrant fold and fixed-point scaling.
   gph_prerot u_prerot (
      .clock   (clock),
      .reset   (reset),
      .enable  (adv[0]),
      .in_vld  (req_valid),
      .grad_x  (req_grad_x),
      .grad_y  (req_grad_y),
      .stage_q (stg[0])
   );

   // CORDIC iterations, one register each.
   generate
      for (k = 0; k < NumStages; k++) begin : g_cordic
         gph_cordic_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .enable    (adv[k+1]),
            .stage_idx (IdxW'(k)),
            .stage_d   (stg[k]),
            .stage_q   (stg[k+1])
         );
      end
   endgenerate

   // Quantization into the response register.
   gph_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv[NumStages+1]),
      .stage_d   (stg[NumStages]),
      .out_vld   (rsp_valid),
      .out_phase (rsp_phase)
   );

   // Requests are refused only when every stage is full and the response waits.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stg[0].vld && stg[NumStages].vld && rsp_valid && rsp_stall))
      else $error("Request refused while the pipeline has room.");

   // The fold always leaves the vector in the right half plane.
   a_fold_right_half: assert property (@(posedge clock) disable iff (reset)
      stg[0].vld |-> !stg[0].x[XW-1])
      else $error("Folded vector has a negative x coordinate.");

   // A vector on the negative x axis is seeded with an angle of pi.
   a_neg_axis_seed: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_grad_y == 0 && req_grad_x[GradW-1])
      |=> (stg[0].z == PiUnits && stg[0].y == '0))
      else $error("Negative x axis not seeded with pi.");

   // A held response keeps its code while the stall lasts.
   a_quant_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_phase)))
      else $error("Response register changed under stall.");

endmodule

FILE: hw/rtl/gph_prerot.sv
// ----------------------------------------------------------------------------
// gph_prerot
// Input stage: scales the gradients to fixed point and folds the vector
// into the right half plane, seeding the angle accordingly.
// ----------------------------------------------------------------------------
module gph_prerot
   import gph_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_vld,
   input  logic signed [GradW-1:0] grad_x,
   input  logic signed [GradW-1:0] grad_y,
   output gph_stage_type           stage_q
);

   logic signed [XW-1:0] gx_s;
   logic signed [XW-1:0] gy_s;
   logic [XW-1:0]        x_in;
   logic [XW-1:0]        y_in;
   logic [ZW-1:0]        z_in;
   logic                 vld_ff;
   logic [XW-1:0]        x_ff;
   logic [XW-1:0]        y_ff;
   logic [ZW-1:0]        z_ff;

   // Sign-extend and scale by 2^FracW.
   assign gx_s = $signed({{(XW-GradW-FracW){grad_x[GradW-1]}}, grad_x, {FracW{1'b0}}});
   assign gy_s = $signed({{(XW-GradW-FracW){grad_y[GradW-1]}}, grad_y, {FracW{1'b0}}});

   // Quadrant fold: negative x axis, upper left and lower left quadrants.
   always_comb begin
      x_in = gx_s;
      y_in = gy_s;
      z_in = '0;
      if (gy_s == 0 && gx_s < 0) begin
         x_in = -gx_s;
         z_in = PiUnits;
      end else if (gx_s <= 0 && gy_s > 0) begin
         x_in = gy_s;
         y_in = -gx_s;
         z_in = HalfPiUnits;
      end else if (gx_s <= 0 && gy_s < 0) begin
         x_in = -gy_s;
         y_in = gx_s;
         z_in = -HalfPiUnits;
      end
   end

   // Valid bit is control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign stage_q = '{vld: vld_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

FILE: hw/rtl/gph_cordic_stage.sv
// ----------------------------------------------------------------------------
// gph_cordic_stage
// One vectoring iteration of the CORDIC: rotates the vector toward the
// x axis by atan(2^-i) and accumulates the angle, then registers it.
// ----------------------------------------------------------------------------
module gph_cordic_stage
   import gph_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic [IdxW-1:0] stage_idx,
   input  gph_stage_type   stage_d,
   output gph_stage_type   stage_q
);

   logic signed [XW-1:0] x_s;
   logic signed [XW-1:0] y_s;
   logic [XW-1:0]        dx;
   logic [XW-1:0]        dy;
   logic [ZW-1:0]        step;
   logic [XW-1:0]        x_in;
   logic [XW-1:0]        y_in;
   logic [ZW-1:0]        z_in;
   logic                 vld_ff;
   logic [XW-1:0]        x_ff;
   logic [XW-1:0]        y_ff;
   logic [ZW-1:0]        z_ff;

   // Arithmetic shifts of both coordinates by the stage index.
   assign x_s  = $signed(stage_d.x);
   assign y_s  = $signed(stage_d.y);
   assign dx   = y_s >>> stage_idx;
   assign dy   = x_s >>> stage_idx;
   assign step = gph_atan(stage_idx);

   // Rotate against the sign of y; a vector on the axis stays put.
   always_comb begin
      x_in = stage_d.x;
      y_in = stage_d.y;
      z_in = stage_d.z;
      if (y_s > 0) begin
         x_in = stage_d.x + dx;
         y_in = stage_d.y - dy;
         z_in = stage_d.z + step;
      end else if (y_s < 0) begin
         x_in = stage_d.x - dx;
         y_in = stage_d.y + dy;
         z_in = stage_d.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff <= stage_d.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign stage_q = '{vld: vld_ff, x: x_ff, y: y_ff, z: z_ff};

endmodule

FILE: hw/rtl/gph_quant.sv
// ----------------------------------------------------------------------------
// gph_quant
// Output stage: offsets the angle by pi, keeps the top eight bits and
// saturates to the phase range, into the response register.
// ----------------------------------------------------------------------------
module gph_quant
   import gph_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  gph_stage_type     stage_d,
   output logic              out_vld,
   output logic [PhaseW-1:0] out_phase
);

   logic signed [ZW:0]  acc;
   logic [PhaseW-1:0]   phase_in;
   logic                vld_ff;
   logic [PhaseW-1:0]   phase_ff;

   // Shift the angle so that -pi maps to zero.
   assign acc = $signed({stage_d.z[ZW-1], stage_d.z}) + $signed({1'b0, PiUnits});

   // Clamp below -pi to 0 and at or above +pi to the top code.
   always_comb begin
      if (acc[ZW]) begin
         phase_in = '0;
      end else if (acc[ZW-1:FracW+PhaseW] != '0) begin
         phase_in = '1;
      end else begin
         phase_in = acc[FracW+PhaseW-1:FracW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff <= stage_d.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         phase_ff <= phase_in;
      end
   end

   assign out_vld   = vld_ff;
   assign out_phase = phase_ff;

endmodule

FILE: tb/tb_gradient_phase_u8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gradient_phase_u8
// Self-checking bench for the 8-bit gradient phase pipeline. A driver sends
// gradient pairs from a queue. A bit-accurate CORDIC predictor works out the
// phase of every accepted request. A monitor compares each response against
// the oldest prediction. Random idle bursts on both channels exercise the
// valid/stall handshake.
// ----------------------------------------------------------------------------
module tb_gradient_phase_u8
   import gph_pkg::*;
();

   localparam int     CalmTail   = 150;   // last requests are sent with no idling
   localparam int     QuietLimit = 2000;  // cycles with no handshake before giving up
   localparam int     MaxReports = 10;
   localparam longint PiAngle    = 64'sd2147483648;
   localparam longint HalfPi     = 64'sd1073741824;

   typedef struct packed {
      logic signed [GradW-1:0] gx;
      logic signed [GradW-1:0] gy;
   } grad_pair_type;

   typedef struct packed {
      grad_pair_type     pair;
      logic [PhaseW-1:0] phase;
   } phase_expect_type;

   // Arctangent of 2^-i in units of pi/2^31.
   longint atan_step [0:23] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [GradW-1:0] req_grad_x = '0;
   logic signed [GradW-1:0] req_grad_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PhaseW-1:0]       rsp_phase;

   grad_pair_type    pending_pairs [$];
   phase_expect_type phase_expected [$];

   int sent_count    = 0;
   int checked_count = 0;
   int mismatches    = 0;
   int top_count     = 0;
   int bottom_count  = 0;
   int level_count   = 0;
   int quiet_cycles  = 0;
   int send_gap      = 0;
   int stall_left    = 0;
   bit timed_out     = 1'b0;

   gradient_phase_u8 u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_grad_x (req_grad_x),
      .req_grad_y (req_grad_y),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_phase  (rsp_phase)
   );

   always #6 clock = ~clock;

   // Phase of one gradient pair: quadrant fold, vectoring CORDIC, then
   // offset by pi and truncation to eight bits with clamping.
   function automatic logic [PhaseW-1:0] atan2_phase(input grad_pair_type pair);
      longint x, y, z, t, dx, dy, acc;
      int     i;
      x = longint'(pair.gx) <<< FracW;
      y = longint'(pair.gy) <<< FracW;
      z = 0;
      if (y == 0 && x < 0) begin
         x = -x;
         z = PiAngle;
      end else if (x <= 0 && y > 0) begin
         t = x; x = y; y = -t;
         z = HalfPi;
      end else if (x <= 0 && y < 0) begin
         t = x; x = -y; y = t;
         z = -HalfPi;
      end
      for (i = 0; i < NumStages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + atan_step[i];
         end else if (y < 0) begin
            x = x - dx; y = y + dy; z = z - atan_step[i];
         end
      end
      acc = z + PiAngle;
      if (acc < 0)
         return '0;
      acc = acc >>> FracW;
      if (acc > 255)
         return '1;
      return PhaseW'(acc);
   endfunction

   // Idling is off near the end of the run and in every fourth stretch
   // of 160 requests.
   function automatic bit idling_allowed();
      return (pending_pairs.size() > CalmTail) && ((sent_count / 160) % 4 != 3);
   endfunction

   // Request driver: a new pair is presented only once the current one has
   // been accepted, or when nothing is being offered.
   always @(posedge clock) begin
      grad_pair_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_pairs.size() != 0) begin
            next_pair  = pending_pairs.pop_front();
            req_grad_x <= next_pair.gx;
            req_grad_y <= next_pair.gy;
            req_valid  <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 14) == 0)
               send_gap <= $urandom_range(1, 19);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Every accepted request gets its predicted phase queued.
   always @(posedge clock) begin
      phase_expect_type entry;
      if (!reset && req_valid && !req_stall) begin
         entry.pair.gx = req_grad_x;
         entry.pair.gy = req_grad_y;
         entry.phase   = atan2_phase(entry.pair);
         phase_expected.push_back(entry);
         sent_count++;
      end
   end

   // Response stall: asserted in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response monitor: each accepted phase is checked against the oldest
   // prediction.
   always @(posedge clock) begin
      phase_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (phase_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t: response with no request pending, phase=%0d",
                        $realtime, rsp_phase);
         end else begin
            want = phase_expected.pop_front();
            checked_count++;
            if (want.phase == 8'd255) top_count++;
            if (want.phase == 8'd0) bottom_count++;
            if (want.phase == 8'd128) level_count++;
            if (rsp_phase !== want.phase) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("%0t: gx=%0d gy=%0d phase expected %0d, got %0d",
                           $realtime, want.pair.gx, want.pair.gy, want.phase,
                           rsp_phase);
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel completes a handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Stimulus and end of run.
   initial begin
      grad_pair_type pair;
      int            sel;
      int            mag;
      int            n;
      int            corner [7];

      corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};

      // Directed: zero vector, each axis, the negative x axis at +pi,
      // near-pi overshoot on both sides, diagonals and full-scale corners.
      pending_pairs.push_back('{16'sd0, 16'sd0});
      pending_pairs.push_back('{-16'sd1, 16'sd0});
      pending_pairs.push_back('{-16'sd5, 16'sd0});
      pending_pairs.push_back('{-16'sd32768, 16'sd0});
      pending_pairs.push_back('{16'sd1, 16'sd0});
      pending_pairs.push_back('{16'sd32767, 16'sd0});
      pending_pairs.push_back('{16'sd0, 16'sd1});
      pending_pairs.push_back('{16'sd0, 16'sd32767});
      pending_pairs.push_back('{16'sd0, -16'sd1});
      pending_pairs.push_back('{16'sd0, -16'sd32768});
      pending_pairs.push_back('{-16'sd32768, 16'sd1});
      pending_pairs.push_back('{-16'sd32768, -16'sd1});
      pending_pairs.push_back('{-16'sd32767, 16'sd1});
      pending_pairs.push_back('{-16'sd32767, -16'sd1});
      pending_pairs.push_back('{16'sd1, 16'sd1});
      pending_pairs.push_back('{-16'sd1, 16'sd1});
      pending_pairs.push_back('{-16'sd1, -16'sd1});
      pending_pairs.push_back('{16'sd1, -16'sd1});
      pending_pairs.push_back('{16'sd32767, 16'sd32767});
      pending_pairs.push_back('{-16'sd32768, -16'sd32768});
      pending_pairs.push_back('{-16'sd32768, 16'sd32767});
      pending_pairs.push_back('{16'sd32767, -16'sd32768});

      // Random: mostly full-range pairs, plus small vectors, the region
      // around the negative x axis, the axes, diagonals and corner values.
      for (n = 0; n < 1430; n++) begin
         sel = $urandom_range(0, 9);
         case (sel)
            5: begin
               pair.gx = GradW'($urandom_range(0, 32) - 16);
               pair.gy = GradW'($urandom_range(0, 32) - 16);
            end
            6: begin
               pair.gx = GradW'(-int'($urandom_range(1, 32768)));
               pair.gy = GradW'($urandom_range(0, 6) - 3);
            end
            7: begin
               if ($urandom_range(0, 1) == 1) begin
                  pair.gx = GradW'($urandom);
                  pair.gy = '0;
               end else begin
                  pair.gx = '0;
                  pair.gy = GradW'($urandom);
               end
            end
            8: begin
               mag     = $urandom_range(1, 32767);
               pair.gx = GradW'(($urandom_range(0, 1) == 1) ? mag : -mag);
               mag     = mag + $urandom_range(0, 2) - 1;
               pair.gy = GradW'(($urandom_range(0, 1) == 1) ? mag : -mag);
            end
            9: begin
               pair.gx = GradW'(corner[$urandom_range(0, 6)]);
               pair.gy = GradW'(corner[$urandom_range(0, 6)]);
            end
            default: begin
               pair.gx = GradW'($urandom);
               pair.gy = GradW'($urandom);
            end
         endcase
         pending_pairs.push_back(pair);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            while (pending_pairs.size() != 0 || req_valid || phase_expected.size() != 0)
               @(posedge clock);
            repeat (NumStages + 10) @(posedge clock);
         end
         begin
            while (quiet_cycles < QuietLimit)
               @(posedge clock);
            timed_out = 1'b1;
         end
      join_any
      disable fork;

      $display("Checked %0d phases over %0d gradient pairs (%0d at the +pi limit,",
               checked_count, sent_count, top_count);
      $display("%0d at -pi, %0d at zero angle), %0d mismatches.",
               bottom_count, level_count, mismatches);
      if (!timed_out && mismatches == 0 && phase_expected.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
